>>> rtl/core/cfd_pkg.sv
`default_nettype none

package cfd_pkg;

  // default payload buffer depth in bytes
  localparam int unsigned BUFFER_BYTES_DEF = 64;

  // frame queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // header and request characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_HASH   = 8'h23;

  // reset values of the configuration registers
  localparam logic       MAIN_PORT_RST   = 1'b1;
  localparam logic [7:0] REBOOT_CHAR_RST = 8'd82;

  typedef enum logic [0:0] {
    CFG_MAIN_PORT   = 1'b0,
    CFG_REBOOT_CHAR = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_CLI     = 2'd2,
    KIND_REBOOT  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_M     = 3'd2,
    PH_ARROW = 3'd3,
    PH_SIZE  = 3'd4,
    PH_CMD   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_READ = 2'd1,
    BK_EMIT = 2'd2
  } bk_state_e;

  // one job handed from the parser to the emitter
  typedef struct packed {
    kind_e      kind;
    logic [7:0] command;
    logic [7:0] size;
  } job_t;

endpackage

`default_nettype wire

>>> rtl/core/cfd_front.sv
`default_nettype none

module cfd_front #(
  parameter int unsigned BUFFER_BYTES = cfd_pkg::BUFFER_BYTES_DEF,
  parameter int unsigned SIZE_W       = $clog2(BUFFER_BYTES + 1),
  parameter int unsigned ADDR_W       = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic              armed_i,
  input  wire logic              main_port_i,
  input  wire logic [7:0]        reboot_char_i,
  output logic                   push_o,
  output cfd_pkg::job_t          job_o,
  input  wire logic              q_full_i,
  output logic                   wr_en_o,
  output logic [ADDR_W-1:0]      wr_addr_o,
  output logic [7:0]             wr_data_o,
  input  wire logic              release_i,
  output logic                   locked_o
);
  import cfd_pkg::*;

  phase_e            phase_q, phase_d;
  logic [SIZE_W-1:0] exp_size_q, exp_size_d;
  logic [SIZE_W-1:0] rcv_cnt_q, rcv_cnt_d;
  logic [7:0]        cmd_q, cmd_d;
  logic [7:0]        xor_q, xor_d;
  logic              locked_q, locked_d;

  logic in_xfer;
  logic cnt_done;
  logic too_big;
  logic payload_phase;
  logic may_push;

  assign cnt_done      = (rcv_cnt_q == exp_size_q);
  assign too_big       = ({1'b0, rx_byte_i} > 9'(BUFFER_BYTES));
  assign payload_phase = (phase_q == PH_CMD) && !cnt_done;
  assign may_push      = (phase_q == PH_IDLE) || ((phase_q == PH_CMD) && cnt_done);

  // hold off payload writes while the buffer is being sent, and results when the queue is full
  assign in_stall_o = (payload_phase && locked_q) || (may_push && q_full_i);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // next parse phase
  always_comb begin
    phase_d = phase_q;
    if (in_xfer) begin
      case (phase_q)
        PH_IDLE:  if (rx_byte_i == CH_DOLLAR) phase_d = PH_START;
        PH_START: phase_d = (rx_byte_i == CH_M) ? PH_M : PH_IDLE;
        PH_M:     phase_d = (rx_byte_i == CH_LT) ? PH_ARROW : PH_IDLE;
        PH_ARROW: phase_d = too_big ? PH_IDLE : PH_SIZE;
        PH_SIZE:  phase_d = PH_CMD;
        PH_CMD:   if (cnt_done) phase_d = PH_IDLE;
        default:  phase_d = PH_IDLE;
      endcase
    end
  end

  // datapath, buffer writes and job generation
  always_comb begin
    exp_size_d    = exp_size_q;
    rcv_cnt_d     = rcv_cnt_q;
    cmd_d         = cmd_q;
    xor_d         = xor_q;
    push_o        = 1'b0;
    job_o.kind    = KIND_CLI;
    job_o.command = 8'd0;
    job_o.size    = 8'd0;
    wr_en_o       = 1'b0;
    wr_addr_o     = rcv_cnt_q[ADDR_W-1:0];
    wr_data_o     = rx_byte_i;
    if (in_xfer) begin
      case (phase_q)
        PH_IDLE: begin
          if (rx_byte_i != CH_DOLLAR && !armed_i && main_port_i) begin
            if (rx_byte_i == CH_HASH) begin
              push_o     = 1'b1;
              job_o.kind = KIND_CLI;
            end else if (rx_byte_i == reboot_char_i) begin
              push_o     = 1'b1;
              job_o.kind = KIND_REBOOT;
            end
          end
        end
        PH_ARROW: begin
          if (!too_big) begin
            exp_size_d = SIZE_W'(rx_byte_i);
            rcv_cnt_d  = '0;
            xor_d      = rx_byte_i;
          end
        end
        PH_SIZE: begin
          cmd_d = rx_byte_i;
          xor_d = xor_q ^ rx_byte_i;
        end
        PH_CMD: begin
          if (!cnt_done) begin
            xor_d     = xor_q ^ rx_byte_i;
            wr_en_o   = 1'b1;
            rcv_cnt_d = rcv_cnt_q + 1'b1;
          end else if (xor_q == rx_byte_i) begin
            push_o        = 1'b1;
            job_o.command = cmd_q;
            job_o.size    = 8'(exp_size_q);
            job_o.kind    = (exp_size_q == '0) ? KIND_EMPTY : KIND_PAYLOAD;
          end
        end
        default: ;
      endcase
    end
  end

  // buffer ownership: taken by a payload job, given back by the emitter
  always_comb begin
    locked_d = locked_q;
    if (release_i) locked_d = 1'b0;
    if (push_o && job_o.kind == KIND_PAYLOAD) locked_d = 1'b1;
  end

  assign locked_o = locked_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      exp_size_q <= '0;
      rcv_cnt_q  <= '0;
      cmd_q      <= '0;
      xor_q      <= '0;
      locked_q   <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      exp_size_q <= exp_size_d;
      rcv_cnt_q  <= rcv_cnt_d;
      cmd_q      <= cmd_d;
      xor_q      <= xor_d;
      locked_q   <= locked_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/cfd_queue.sv
`default_nettype none

module cfd_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire cfd_pkg::job_t  push_job_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output cfd_pkg::job_t       pop_job_o,
  output logic                empty_o
);
  import cfd_pkg::*;

  job_t               slots_q [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0] cnt_q;

  assign full_o    = (cnt_q == Q_CNT_W'(QUEUE_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign pop_job_o = slots_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_ptr_q] <= push_job_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/cfd_back.sv
`default_nettype none

module cfd_back #(
  parameter int unsigned BUFFER_BYTES = cfd_pkg::BUFFER_BYTES_DEF,
  parameter int unsigned SIZE_W       = $clog2(BUFFER_BYTES + 1),
  parameter int unsigned ADDR_W       = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_empty_i,
  input  wire cfd_pkg::job_t     q_job_i,
  output logic                   pop_o,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [7:0]        wr_data_i,
  output logic                   release_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [1:0]             kind_o,
  output logic [7:0]             command_o,
  output logic [6:0]             frame_size_o,
  output logic [5:0]             byte_index_o,
  output logic [7:0]             payload_byte_o,
  output logic                   last_o
);
  import cfd_pkg::*;

  logic [7:0] mem [BUFFER_BYTES];

  bk_state_e         state_q, state_d;
  job_t              job_q;
  logic [SIZE_W-1:0] idx_q;
  logic [SIZE_W-1:0] idx_inc;
  logic [7:0]        rdata_q;
  logic              out_valid_q;
  logic [1:0]        kind_q;
  logic [7:0]        command_q;
  logic [6:0]        frame_size_q;
  logic [5:0]        byte_index_q;
  logic [7:0]        payload_byte_q;
  logic              last_q;

  logic is_payload;
  logic is_last;
  logic out_free;
  logic load;

  assign is_payload = (job_q.kind == KIND_PAYLOAD);
  assign idx_inc    = idx_q + 1'b1;
  assign is_last    = !is_payload || (idx_inc == SIZE_W'(job_q.size));
  assign out_free   = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) state_d = (q_job_i.kind == KIND_PAYLOAD) ? BK_READ : BK_EMIT;
      end
      BK_READ: state_d = BK_EMIT;
      BK_EMIT: begin
        if (out_free) state_d = is_last ? BK_IDLE : BK_READ;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o     = (state_q == BK_IDLE) && !q_empty_i;
    load      = (state_q == BK_EMIT) && out_free;
    release_o = load && is_payload && is_last;
  end

  // payload buffer, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    if (state_q == BK_READ) rdata_q <= mem[idx_q[ADDR_W-1:0]];
  end

  // job and result payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= q_job_i;
    if (load) begin
      kind_q         <= job_q.kind;
      command_q      <= job_q.command;
      frame_size_q   <= 7'(job_q.size);
      byte_index_q   <= is_payload ? 6'(idx_q) : 6'd0;
      payload_byte_q <= is_payload ? rdata_q : 8'd0;
      last_q         <= is_last;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o)     idx_q <= '0;
      else if (load) idx_q <= idx_inc;
      if (load)                          out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign command_o      = command_q;
  assign frame_size_o   = frame_size_q;
  assign byte_index_o   = byte_index_q;
  assign payload_byte_o = payload_byte_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

>>> rtl/core/command_frame_deframer.sv
// Request-frame deframer for a serial byte stream.
// Input channel: one received byte (rx_byte_i, armed_i) per transfer on
// in_valid_i / in_stall_o. Output channel: one result per transfer on
// out_valid_o / out_stall_i, carrying kind, command, frame size, byte index,
// payload byte and a last mark on the final result of each frame or request.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 main_port, 1 reboot char) at a clock edge; write only while idle.
// Throughput: the parser takes one byte per cycle. It stalls a payload byte
// while the previous frame's payload is still being sent from the buffer,
// and a possibly result-bearing byte while the two-entry frame queue is full.
// Order: after the checksum byte transfers, the frame's job enters the frame
// queue, the emitter pops it, and each payload result takes one buffer read
// plus one output load; a CLI, reboot or empty-command result is loaded into
// the output register after the pop, with no buffer read.
// Reset clears the parser to idle, empties the queue, drops any output and
// restores main_port = 1 and the reboot char = 82. The payload buffer is not
// cleared; only entries of the current frame are ever read.
// When the receiver stalls, the output register holds its result, the
// emitter waits, and the parser keeps accepting header bytes.
`default_nettype none

module command_frame_deframer #(
  parameter int unsigned BUFFER_BYTES = cfd_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       armed_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      command_o,
  output logic [6:0]      frame_size_o,
  output logic [5:0]      byte_index_o,
  output logic [7:0]      payload_byte_o,
  output logic            last_o,
  input  wire logic       cfg_we_i,
  input  wire logic [0:0] cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i
);
  import cfd_pkg::*;

  localparam int unsigned SIZE_W = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned ADDR_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

  logic       main_port_q;
  logic [7:0] reboot_char_q;

  logic              push;
  job_t              push_job;
  logic              q_full;
  logic              q_empty;
  logic              pop;
  job_t              pop_job;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              release_buf;
  logic              locked;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_port_q   <= MAIN_PORT_RST;
      reboot_char_q <= REBOOT_CHAR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAIN_PORT:   main_port_q   <= cfg_wdata_i[0];
        CFG_REBOOT_CHAR: reboot_char_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  cfd_front #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .SIZE_W       (SIZE_W),
    .ADDR_W       (ADDR_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .armed_i       (armed_i),
    .main_port_i   (main_port_q),
    .reboot_char_i (reboot_char_q),
    .push_o        (push),
    .job_o         (push_job),
    .q_full_i      (q_full),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data),
    .release_i     (release_buf),
    .locked_o      (locked)
  );

  cfd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .pop_job_o  (pop_job),
    .empty_o    (q_empty)
  );

  cfd_back #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .SIZE_W       (SIZE_W),
    .ADDR_W       (ADDR_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_job_i        (pop_job),
    .pop_o          (pop),
    .wr_en_i        (wr_en),
    .wr_addr_i      (wr_addr),
    .wr_data_i      (wr_data),
    .release_o      (release_buf),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .command_o      (command_o),
    .frame_size_o   (frame_size_o),
    .byte_index_o   (byte_index_o),
    .payload_byte_o (payload_byte_o),
    .last_o         (last_o)
  );

  // the parser never overwrites the buffer while its payload is being sent
  a_no_write_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !locked)
    else $error("payload buffer written while locked");

  // no job is pushed into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("frame queue overflow");

  // the buffer is only given back while it is held
  a_release_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    release_buf |-> locked)
    else $error("buffer released while not locked");

  // single-result kinds always carry the last mark
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_PAYLOAD) |-> last_o)
    else $error("non-payload result without last mark");

endmodule

`default_nettype wire

>>> verif/tb_command_frame_deframer.sv
`timescale 1ns / 1ps

module tb_command_frame_deframer;
  import cfd_pkg::*;

  localparam int unsigned BUF_DEPTH      = BUFFER_BYTES_DEF;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // one received byte waiting to be sent
  typedef struct {
    logic [7:0] rx;
    logic       arm;
  } rx_item_t;

  // one predicted result transfer
  typedef struct {
    kind_e      kind;
    logic [7:0] command;
    logic [6:0] frame_size;
    logic [5:0] idx;
    logic [7:0] data;
    logic       last;
  } frame_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte  = 8'h00;
  logic       armed    = 1'b0;
  logic       out_valid_o;
  logic       out_stall = 1'b0;
  logic [1:0] kind_o;
  logic [7:0] command_o;
  logic [6:0] frame_size_o;
  logic [5:0] byte_index_o;
  logic [7:0] payload_byte_o;
  logic       last_o;
  logic       cfg_we    = 1'b0;
  cfg_idx_e   cfg_idx   = CFG_MAIN_PORT;
  logic [7:0] cfg_wdata = 8'h00;

  rx_item_t      rx_queue[$];
  frame_result_t result_queue[$];
  int unsigned   queued_cnt   = 0;
  int unsigned   mismatch_cnt = 0;
  int unsigned   idle_cycles  = 0;
  bit            steady       = 1'b0;

  // shadow of the configuration registers
  logic       main_port_q   = MAIN_PORT_RST;
  logic [7:0] reboot_char_q = REBOOT_CHAR_RST;

  // shadow of the parser state
  phase_e     parse_ph  = PH_IDLE;
  logic [6:0] want_len  = '0;
  logic [6:0] got_len   = '0;
  logic [7:0] frame_cmd = '0;
  logic [7:0] run_xor   = '0;
  logic [7:0] pay_buf[BUF_DEPTH];

  command_frame_deframer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte),
    .armed_i       (armed),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .kind_o        (kind_o),
    .command_o     (command_o),
    .frame_size_o  (frame_size_o),
    .byte_index_o  (byte_index_o),
    .payload_byte_o(payload_byte_o),
    .last_o        (last_o),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void push_result(kind_e k, logic [7:0] cmd, logic [6:0] len,
                                      logic [5:0] idx, logic [7:0] data, logic last);
    frame_result_t r;
    r = '{kind: k, command: cmd, frame_size: len, idx: idx, data: data, last: last};
    result_queue.push_back(r);
  endfunction

  // advance the shadow parser by one received byte and queue what it emits
  function automatic void parse_rx_byte(logic [7:0] c, logic arm);
    int unsigned i;
    case (parse_ph)
      PH_IDLE: begin
        if (c == CH_DOLLAR) begin
          parse_ph = PH_START;
        end else if (!arm && main_port_q) begin
          if (c == CH_HASH) push_result(KIND_CLI, '0, '0, '0, '0, 1'b1);
          else if (c == reboot_char_q) push_result(KIND_REBOOT, '0, '0, '0, '0, 1'b1);
        end
      end
      PH_START: parse_ph = (c == CH_M) ? PH_M : PH_IDLE;
      PH_M:     parse_ph = (c == CH_LT) ? PH_ARROW : PH_IDLE;
      PH_ARROW: begin
        if (c > BUF_DEPTH) begin
          parse_ph = PH_IDLE;
        end else begin
          want_len = c[6:0];
          got_len  = '0;
          run_xor  = c;
          parse_ph = PH_SIZE;
        end
      end
      PH_SIZE: begin
        frame_cmd = c;
        run_xor   = run_xor ^ c;
        parse_ph  = PH_CMD;
      end
      PH_CMD: begin
        if (got_len < want_len) begin
          run_xor               = run_xor ^ c;
          pay_buf[got_len[5:0]] = c;
          got_len               = got_len + 1'b1;
        end else begin
          // checksum byte: release the frame only on a match
          if (run_xor == c) begin
            if (want_len == 0) begin
              push_result(KIND_EMPTY, frame_cmd, '0, '0, '0, 1'b1);
            end else begin
              for (i = 0; i < want_len; i++)
                push_result(KIND_PAYLOAD, frame_cmd, want_len, i[5:0], pay_buf[i[5:0]],
                            (i + 1 == want_len));
            end
          end
          parse_ph = PH_IDLE;
        end
      end
      default: parse_ph = PH_IDLE;
    endcase
  endfunction

  function automatic logic rand_arm();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic void push_rx(logic [7:0] c, logic arm);
    rx_item_t it;
    it = '{rx: c, arm: arm};
    rx_queue.push_back(it);
    queued_cnt++;
  endfunction

  // complete request frame, optionally with a corrupted checksum
  function automatic void add_frame(logic [6:0] len, logic [7:0] cmd, bit bad_sum);
    logic [7:0] sum;
    logic [7:0] val;
    int unsigned i;
    push_rx(CH_DOLLAR, rand_arm());
    push_rx(CH_M, rand_arm());
    push_rx(CH_LT, rand_arm());
    push_rx({1'b0, len}, rand_arm());
    push_rx(cmd, rand_arm());
    sum = {1'b0, len} ^ cmd;
    for (i = 0; i < len; i++) begin
      val = 8'($urandom_range(0, 255));
      sum = sum ^ val;
      push_rx(val, rand_arm());
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    push_rx(sum, rand_arm());
  endfunction

  // mostly well-formed frames, the rest noise and broken headers
  function automatic void add_random(int unsigned n_items);
    int unsigned start_cnt;
    int unsigned pick;
    int unsigned len;
    int unsigned n;
    logic [7:0]  c;
    start_cnt = queued_cnt;
    while (queued_cnt - start_cnt < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        n = $urandom_range(0, 99);
        if (n < 85) len = $urandom_range(0, 8);
        else if (n < 95) len = $urandom_range(9, 63);
        else len = BUF_DEPTH;
        add_frame(len[6:0], 8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end else if (pick < 75) begin
        n = $urandom_range(0, 2);
        if (n == 0) c = CH_HASH;
        else if (n == 1) c = reboot_char_q;
        else c = 8'($urandom_range(0, 255));
        push_rx(c, rand_arm());
      end else if (pick < 85) begin
        push_rx(CH_DOLLAR, rand_arm());
        if ($urandom_range(0, 1) != 0) begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_M);
        end else begin
          push_rx(CH_M, rand_arm());
          do c = 8'($urandom_range(0, 255)); while (c == CH_LT);
        end
        push_rx(c, rand_arm());
      end else if (pick < 92) begin
        push_rx(CH_DOLLAR, rand_arm());
        push_rx(CH_M, rand_arm());
        push_rx(CH_LT, rand_arm());
        push_rx(8'($urandom_range(BUF_DEPTH + 1, 255)), rand_arm());
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) push_rx(8'($urandom_range(0, 255)), rand_arm());
      end
    end
  endfunction

  // wait until all bytes are sent and every predicted result has arrived
  task automatic wait_results_done();
    while (rx_queue.size() != 0 || in_valid) @(posedge clk_i);
    while (result_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_MAIN_PORT:   main_port_q   = val[0];
      CFG_REBOOT_CHAR: reboot_char_q = val;
      default: ;
    endcase
  endtask

  // stimulus sequence
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // requests at idle, armed and unarmed
    push_rx(CH_HASH, 1'b0);
    push_rx(REBOOT_CHAR_RST, 1'b0);
    push_rx(CH_HASH, 1'b1);
    push_rx(REBOOT_CHAR_RST, 1'b1);
    // empty command frame
    push_rx(CH_DOLLAR, 1'b0);
    push_rx(CH_M, 1'b0);
    push_rx(CH_LT, 1'b0);
    push_rx(8'h00, 1'b0);
    push_rx(8'hA5, 1'b0);
    push_rx(8'hA5, 1'b0);
    // second start char is not taken as a new start
    push_rx(CH_DOLLAR, 1'b0);
    push_rx(CH_DOLLAR, 1'b0);
    push_rx(CH_HASH, 1'b0);
    // header mismatch after 'M'
    push_rx(CH_DOLLAR, 1'b1);
    push_rx(CH_M, 1'b1);
    push_rx(8'h00, 1'b1);
    // oversized frame
    push_rx(CH_DOLLAR, 1'b0);
    push_rx(CH_M, 1'b0);
    push_rx(CH_LT, 1'b0);
    push_rx(8'(BUF_DEPTH + 1), 1'b0);
    // checksum mismatch is dropped
    push_rx(CH_DOLLAR, 1'b0);
    push_rx(CH_M, 1'b0);
    push_rx(CH_LT, 1'b0);
    push_rx(8'h01, 1'b0);
    push_rx(8'hFF, 1'b0);
    push_rx(8'hFF, 1'b0);
    push_rx(8'h00, 1'b1);
    wait_results_done();

    // requests disabled, reboot char at zero
    write_reg(CFG_MAIN_PORT, 8'h00);
    write_reg(CFG_REBOOT_CHAR, 8'h00);
    push_rx(CH_HASH, 1'b0);
    push_rx(8'h00, 1'b0);
    add_random(12);
    wait_results_done();

    // no idling at all, plus a full pause halfway
    write_reg(CFG_MAIN_PORT, 8'h01);
    write_reg(CFG_REBOOT_CHAR, 8'hFF);
    steady = 1'b1;
    add_random(8);
    wait_results_done();
    add_random(8);
    wait_results_done();
    steady = 1'b0;

    // reboot char equal to the CLI char
    write_reg(CFG_REBOOT_CHAR, CH_HASH);
    push_rx(CH_HASH, 1'b0);
    add_random(10);
    wait_results_done();

    // reboot char equal to the start char
    write_reg(CFG_REBOOT_CHAR, CH_DOLLAR);
    push_rx(CH_DOLLAR, 1'b0);
    push_rx(CH_M, 1'b0);
    add_random(10);
    wait_results_done();

    // back to a plain reboot char, with a full-size frame
    write_reg(CFG_REBOOT_CHAR, 8'h00);
    add_frame(7'(BUF_DEPTH), 8'hFF, 1'b0);
    add_random(10);
    wait_results_done();

    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // driver: present queued bytes, predict on each transfer
  always @(posedge clk_i) begin
    bit go;
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        parse_rx_byte(rx_byte, armed);
        void'(rx_queue.pop_front());
      end
      if (!in_valid || !in_stall_o) begin
        go = (rx_queue.size() != 0) && (steady || $urandom_range(0, 99) >= 24);
        in_valid <= go;
        if (go) begin
          rx_byte <= rx_queue[0].rx;
          armed   <= rx_queue[0].arm;
        end
      end
    end
  end

  function automatic void cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // monitor: check each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (result_queue.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d cmd %0d",
                   $time, kind_o, command_o);
          mismatch_cnt++;
        end else begin
          want = result_queue.pop_front();
          cmp_field("kind", want.kind, kind_o);
          cmp_field("command", want.command, command_o);
          cmp_field("frame_size", want.frame_size, frame_size_o);
          cmp_field("byte_index", want.idx, byte_index_o);
          cmp_field("payload_byte", want.data, payload_byte_o);
          cmp_field("last", want.last, last_o);
        end
      end
      out_stall <= !steady && ($urandom_range(0, 99) < 24);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall) || cfg_we) begin
      idle_cycles <= '0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1'b1;
    end
  end

endmodule

>>> sim.f
rtl/core/cfd_pkg.sv
rtl/core/cfd_front.sv
rtl/core/cfd_queue.sv
rtl/core/cfd_back.sv
rtl/core/command_frame_deframer.sv
verif/tb_command_frame_deframer.sv
